### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

### rtl/hrcd_pkg.sv
// ----------------------------------------------------------------------------
// hrcd_pkg
// Types, constants and character helpers for the HTTP reply deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hrcd_pkg;

   localparam int LINE_BYTES_DEFAULT = 128;

   localparam int TE_LEN = 17;
   localparam int CK_LEN = 7;
   localparam logic [8*TE_LEN-1:0] TE_TEXT = "transfer-encoding";
   localparam logic [8*CK_LEN-1:0] CK_TEXT = "chunked";

   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LC_C  = 8'h63;

   typedef enum logic [2:0] {
      PH_STATUS,
      PH_HEADER,
      PH_BODY,
      PH_SIZE,
      PH_DATA,
      PH_CRLF,
      PH_TRAILER
   } phase_type;

   typedef enum logic [1:0] {
      SCAN_PRE_SPACE,
      SCAN_SKIP_SPACE,
      SCAN_DIGITS,
      SCAN_DONE
   } scan_type;

   typedef struct packed {
      logic        body_valid;
      logic [7:0]  body_byte;
      logic [9:0]  status_code;
      logic        chunked_mode;
      logic        body_finished;
      logic [31:0] body_count;
   } result_type;

   function automatic logic [7:0] te_char(input logic [4:0] pos);
      int idx;
      idx = TE_LEN - 1 - int'(pos);
      if (idx < 0) idx = 0;
      return TE_TEXT[8*idx +: 8];
   endfunction

   function automatic logic [7:0] ck_char(input logic [2:0] pos);
      int idx;
      idx = CK_LEN - 1 - int'(pos);
      if (idx < 0) idx = 0;
      return CK_TEXT[8*idx +: 8];
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b inside {[8'h41:8'h5a]}) ? b + 8'd32 : b;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

   // {hit, value} for one hex character
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [7:0] d;
      d = 8'd0;
      if (b inside {[8'h30:8'h39]}) begin
         d = b - 8'h30;
         return {1'b1, d[3:0]};
      end else if (b inside {[8'h61:8'h66]}) begin
         d = b - 8'h57;
         return {1'b1, d[3:0]};
      end else if (b inside {[8'h41:8'h46]}) begin
         d = b - 8'h37;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

`default_nettype wire

### rtl/hrcd_req_if.sv
// ----------------------------------------------------------------------------
// hrcd_req_if
// Reply byte channel: one received byte and a restart flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_reply;

   modport source (output valid, output data_byte, output start_reply, input ready);
   modport sink   (input valid, input data_byte, input start_reply, output ready);
endinterface

`default_nettype wire

### rtl/hrcd_rsp_if.sv
// ----------------------------------------------------------------------------
// hrcd_rsp_if
// Result channel: body byte and reply status, one item per input byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        body_valid;
   logic [7:0]  body_byte;
   logic [9:0]  status_code;
   logic        chunked_mode;
   logic        body_finished;
   logic [31:0] body_count;

   modport source (output valid, output body_valid, output body_byte, output status_code,
                   output chunked_mode, output body_finished, output body_count,
                   input ready);
   modport sink   (input valid, input body_valid, input body_byte, input status_code,
                   input chunked_mode, input body_finished, input body_count,
                   output ready);
endinterface

`default_nettype wire

### rtl/hrcd_parser.sv
// ----------------------------------------------------------------------------
// hrcd_parser
// Parser state and per-byte next-state logic; state advances on each item.
// ----------------------------------------------------------------------------
`default_nettype none

module hrcd_parser
   import hrcd_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] data_byte,
   input  wire logic       start_reply,
   output result_type      result
);

   localparam int FILL_W = $clog2(LINE_BYTES);
   localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_BYTES - 1);

   phase_type         phase_ff, phase_in, phase_cur;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_cur;
   logic              zend_ff, zend_in, zend_cur;
   logic [9:0]        status_ff, status_in, status_cur;
   scan_type          scan_ff, scan_in, scan_cur;
   logic [1:0]        digits_ff, digits_in, digits_cur;
   logic [9:0]        partial_ff, partial_in, partial_cur;
   logic [4:0]        name_pos_ff, name_pos_in, name_pos_cur;
   logic              mismatch_ff, mismatch_in, mismatch_cur;
   logic [2:0]        word_pos_ff, word_pos_in, word_pos_cur;
   logic              found_ff, found_in, found_cur;
   logic              chunked_ff, chunked_in, chunked_cur;
   logic              hex_act_ff, hex_act_in, hex_act_cur;
   logic [31:0]       remain_ff, remain_in, remain_cur;
   logic [31:0]       total_ff, total_in, total_cur;

   logic       deliver;
   logic       keep;
   logic [7:0] lc;
   logic [4:0] hv;
   logic [3:0] dig;

   // A restart flag clears everything before the byte is looked at.
   always_comb begin
      if (start_reply) begin
         phase_cur    = PH_STATUS;
         fill_cur     = '0;
         zend_cur     = 1'b0;
         status_cur   = '0;
         scan_cur     = SCAN_PRE_SPACE;
         digits_cur   = '0;
         partial_cur  = '0;
         name_pos_cur = '0;
         mismatch_cur = 1'b0;
         word_pos_cur = '0;
         found_cur    = 1'b0;
         chunked_cur  = 1'b0;
         hex_act_cur  = 1'b1;
         remain_cur   = '0;
         total_cur    = '0;
      end else begin
         phase_cur    = phase_ff;
         fill_cur     = fill_ff;
         zend_cur     = zend_ff;
         status_cur   = status_ff;
         scan_cur     = scan_ff;
         digits_cur   = digits_ff;
         partial_cur  = partial_ff;
         name_pos_cur = name_pos_ff;
         mismatch_cur = mismatch_ff;
         word_pos_cur = word_pos_ff;
         found_cur    = found_ff;
         chunked_cur  = chunked_ff;
         hex_act_cur  = hex_act_ff;
         remain_cur   = remain_ff;
         total_cur    = total_ff;
      end
   end

   always_comb begin
      phase_in    = phase_cur;
      fill_in     = fill_cur;
      zend_in     = zend_cur;
      status_in   = status_cur;
      scan_in     = scan_cur;
      digits_in   = digits_cur;
      partial_in  = partial_cur;
      name_pos_in = name_pos_cur;
      mismatch_in = mismatch_cur;
      word_pos_in = word_pos_cur;
      found_in    = found_cur;
      chunked_in  = chunked_cur;
      hex_act_in  = hex_act_cur;
      remain_in   = remain_cur;
      deliver     = 1'b0;
      keep        = 1'b0;
      lc          = to_lower(data_byte);
      hv          = hex_value(data_byte);
      dig         = data_byte[3:0];

      case (phase_cur)
         PH_STATUS, PH_HEADER, PH_SIZE: begin
            if (data_byte == CHAR_LF) begin
               if (phase_cur == PH_STATUS) begin
                  if (digits_cur == 2'd3) status_in = partial_cur;
                  phase_in = PH_HEADER;
               end else if (phase_cur == PH_SIZE) begin
                  phase_in = (remain_cur != 32'd0) ? PH_DATA : PH_TRAILER;
               end else if (fill_cur == '0) begin
                  phase_in = chunked_cur ? PH_SIZE : PH_BODY;
               end else if (!mismatch_cur && name_pos_cur == 5'(TE_LEN) && found_cur) begin
                  chunked_in = 1'b1;
               end
               // clear per-line state
               fill_in     = '0;
               zend_in     = 1'b0;
               scan_in     = SCAN_PRE_SPACE;
               digits_in   = '0;
               partial_in  = '0;
               name_pos_in = '0;
               mismatch_in = 1'b0;
               word_pos_in = '0;
               found_in    = 1'b0;
               hex_act_in  = 1'b1;
            end else if (data_byte != CHAR_CR && fill_cur < FILL_LIMIT) begin
               fill_in = fill_cur + FILL_W'(1);
               keep    = !zend_cur;
            end
         end
         PH_BODY: deliver = 1'b1;
         PH_DATA: begin
            deliver   = 1'b1;
            remain_in = remain_cur - 32'd1;
            if (remain_cur == 32'd1) phase_in = PH_CRLF;
         end
         PH_CRLF: begin
            if (data_byte == CHAR_LF) phase_in = PH_SIZE;
         end
         default: ;
      endcase

      // examine a kept line byte
      if (keep) begin
         if (data_byte == CHAR_NUL) begin
            zend_in    = 1'b1;
            hex_act_in = 1'b0;
         end else if (phase_cur == PH_STATUS) begin
            case (scan_cur)
               SCAN_PRE_SPACE: begin
                  if (data_byte == CHAR_SPACE) scan_in = SCAN_SKIP_SPACE;
               end
               SCAN_SKIP_SPACE: begin
                  if (data_byte != CHAR_SPACE) begin
                     scan_in = SCAN_DONE;
                     if (is_digit(data_byte)) begin
                        partial_in = {6'd0, dig};
                        digits_in  = 2'd1;
                        scan_in    = SCAN_DIGITS;
                     end
                  end
               end
               SCAN_DIGITS: begin
                  if (is_digit(data_byte) && digits_cur != 2'd3) begin
                     partial_in = 10'(partial_cur * 10'd10 + {6'd0, dig});
                     digits_in  = digits_cur + 2'd1;
                     if (digits_cur == 2'd2) scan_in = SCAN_DONE;
                  end else begin
                     scan_in = SCAN_DONE;
                  end
               end
               default: ;
            endcase
         end else if (phase_cur == PH_HEADER) begin
            if (!mismatch_cur) begin
               if (name_pos_cur != 5'(TE_LEN)) begin
                  if (lc == te_char(name_pos_cur)) name_pos_in = name_pos_cur + 5'd1;
                  else mismatch_in = 1'b1;
               end else if (!found_cur) begin
                  if (lc == ck_char(word_pos_cur)) begin
                     word_pos_in = word_pos_cur + 3'd1;
                     if (word_pos_cur == 3'(CK_LEN - 1)) found_in = 1'b1;
                  end else begin
                     word_pos_in = (lc == CHAR_LC_C) ? 3'd1 : 3'd0;
                  end
               end
            end
         end else if (hex_act_cur) begin
            if (hv[4]) remain_in = {remain_cur[27:0], hv[3:0]};
            else hex_act_in = 1'b0;
         end
      end

      total_in = deliver ? total_cur + 32'd1 : total_cur;
   end

   always_comb begin
      result.body_valid    = deliver;
      result.body_byte     = deliver ? data_byte : 8'd0;
      result.status_code   = status_in;
      result.chunked_mode  = chunked_in;
      result.body_finished = (phase_in == PH_TRAILER);
      result.body_count    = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_STATUS;
         fill_ff     <= '0;
         zend_ff     <= 1'b0;
         status_ff   <= '0;
         scan_ff     <= SCAN_PRE_SPACE;
         digits_ff   <= '0;
         partial_ff  <= '0;
         name_pos_ff <= '0;
         mismatch_ff <= 1'b0;
         word_pos_ff <= '0;
         found_ff    <= 1'b0;
         chunked_ff  <= 1'b0;
         hex_act_ff  <= 1'b1;
         remain_ff   <= '0;
         total_ff    <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         fill_ff     <= fill_in;
         zend_ff     <= zend_in;
         status_ff   <= status_in;
         scan_ff     <= scan_in;
         digits_ff   <= digits_in;
         partial_ff  <= partial_in;
         name_pos_ff <= name_pos_in;
         mismatch_ff <= mismatch_in;
         word_pos_ff <= word_pos_in;
         found_ff    <= found_in;
         chunked_ff  <= chunked_in;
         hex_act_ff  <= hex_act_in;
         remain_ff   <= remain_in;
         total_ff    <= total_in;
      end
   end

endmodule

`default_nettype wire

### rtl/http_reply_chunked_deframer.sv
// ----------------------------------------------------------------------------
// http_reply_chunked_deframer
// HTTP/1.1 reply deframer with chunked transfer decoding, one byte per item.
// ----------------------------------------------------------------------------
// Every accepted byte produces exactly one result item in the next cycle, and a
// new byte can be taken every cycle: the parser state registers and the result
// register are the only storage on the path. The request side stalls only while
// a result item sits unaccepted in the result register. Raise start_reply on
// the first byte of each reply to clear all parser state; lines longer than
// LINE_BYTES-1 bytes are truncated for header and size matching.
`default_nettype none

`include "assert_macros.svh"

module http_reply_chunked_deframer
   import hrcd_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   hrcd_req_if.sink  req_chan,
   hrcd_rsp_if.source rsp_chan
);

   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       accept;

   // hold a result until taken, but take a new item in the cycle it leaves
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   hrcd_parser #(
      .LINE_BYTES(LINE_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .data_byte   (req_chan.data_byte),
      .start_reply (req_chan.start_reply),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.body_valid    = rsp_data_ff.body_valid;
   assign rsp_chan.body_byte     = rsp_data_ff.body_byte;
   assign rsp_chan.status_code   = rsp_data_ff.status_code;
   assign rsp_chan.chunked_mode  = rsp_data_ff.chunked_mode;
   assign rsp_chan.body_finished = rsp_data_ff.body_finished;
   assign rsp_chan.body_count    = rsp_data_ff.body_count;

   `ASSERT_AT(a_accept_gives_result, clock, reset, accept |=> rsp_valid_ff)
   `ASSERT_NEVER(a_no_body_after_finish, clock, reset, rsp_valid_ff && rsp_data_ff.body_valid && rsp_data_ff.body_finished)
   `ASSERT_AT(a_idle_byte_zero, clock, reset, (rsp_valid_ff && !rsp_data_ff.body_valid) |-> (rsp_data_ff.body_byte == 8'd0))

endmodule

`default_nettype wire
